// File: hdl/rgbr_pkg.sv
// shared types and constants for the regime-gated band reversion block
`default_nettype none

package rgbr_pkg;

  // fixed field widths
  localparam int unsigned PRICE_W    = 24;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned MULT_W     = 11;
  localparam int unsigned SIG_W      = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_USER_W = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_REGIME_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EFF_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_MULT     = 2'd2;

  // register reset values
  localparam logic              RST_REGIME_ENABLE = 1'b1;
  localparam logic [THR_W-1:0]  RST_EFF_THRESHOLD = 16'd22938;
  localparam logic [MULT_W-1:0] RST_BAND_MULT     = 11'd512;

  // signal codes
  localparam logic [SIG_W-1:0] SIG_NONE  = 2'b00;
  localparam logic [SIG_W-1:0] SIG_LONG  = 2'b01;
  localparam logic [SIG_W-1:0] SIG_SHORT = 2'b11;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_PREV,
    ST_RD_EFF,
    ST_RD_EFF1,
    ST_RD_OLD,
    ST_TAKE_OLD,
    ST_GATE,
    ST_RHS_LO,
    ST_RHS_HI,
    ST_RHS_SUM,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: hdl/rgbr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module rgbr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 20
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/regime_gated_bollinger_reversion.sv
// Bollinger band mean reversion with an efficiency ratio regime gate
//
// One close price is taken per input beat (s_axis): tdata carries the close in
// price ticks, tuser the new-series flag that clears the held history first.
// One result beat (m_axis) follows each input beat: tdata carries the signed
// direction (+1 long, -1 short, 0 none), tuser the ready and gate-blocked flags.
// Settings are written on the cfg channel (index, data); the user must write them
// only while no bar is in flight, which the block does not enforce; cfg_ready_o is always high.
// A bar passes from accept to the next accept through an idle state, four
// window reads through the single ram read port interleaved with the
// shared multiplier, four further multiplier passes (gate product, oldest
// square and the two halves of the wide variance product), an add step and
// the commit step; no new bar is accepted before that commit.
// The result sits in an output register, so a stalled receiver holds the
// block only in its commit cycle until that register is free.
// Reset clears the history (pointer, count, sums, path) and loads the setting
// defaults; the window ram is not cleared, entries are read only once written.
`default_nettype none

module regime_gated_bollinger_reversion #(
  parameter int unsigned BAND_WINDOW       = 20,
  parameter int unsigned EFFICIENCY_LENGTH = 10
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // input bar stream
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire [rgbr_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [23:0] close_price
  input  wire [0:0]                          s_axis_tuser,   // [0] new_series
  // result stream
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [rgbr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [1:0] signal, rest zero
  output logic [rgbr_pkg::OUT_USER_W-1:0]    m_axis_tuser,   // [0] ready_res, [1] regime_blocked
  // configuration writes
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [rgbr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [rgbr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import rgbr_pkg::*;

  // derived widths
  localparam int unsigned LW   = $clog2(BAND_WINDOW);
  localparam int unsigned PTW  = LW;
  localparam int unsigned HCW  = $clog2(BAND_WINDOW + 1);
  localparam int unsigned SW   = PRICE_W + LW;
  localparam int unsigned QW   = 2 * PRICE_W + LW;
  localparam int unsigned DW   = SW;
  localparam int unsigned VW   = 2 * DW;
  localparam int unsigned PLW  = PRICE_W + $clog2(EFFICIENCY_LENGTH);
  localparam int unsigned CW   = 3 * DW;
  localparam int unsigned K2W  = 2 * MULT_W + LW;
  localparam int unsigned CSQW = 2 * PRICE_W;
  localparam int unsigned THPW = PLW + THR_W;

  // settings
  logic              regime_en_q;
  logic [THR_W-1:0]  thr_q;
  logic [MULT_W-1:0] kmul_q;

  // history state
  logic [PTW-1:0]    wp_q;
  logic [HCW-1:0]    count_q;
  logic [SW-1:0]     sum_q;
  logic [QW-1:0]     sq_q;
  logic [PLW-1:0]    path_q;

  // sequencer
  state_e            state_q, state_d;
  logic              accept_s;
  logic              commit_s;

  // bar working registers
  logic [PRICE_W-1:0] c_q, a1_q, ae_q, old_q;
  logic [CSQW-1:0]    csq_q, osq_q;
  logic [VW-1:0]      ss_q, dsq_q, v_q;
  logic [DW-1:0]      d_q;
  logic               d_neg_q, var_pos_q, blocked_q;
  logic [PLW-1:0]     npath_q;
  logic [2*MULT_W-1:0] k2_q;
  logic [K2W-1:0]     k2w_q;
  logic [THPW-1:0]    thp_q;
  logic [CW-1:0]      lhs_q, rhs_q;
  logic [VW-1:0]      rlo_q;

  // shared multiplier
  logic [DW-1:0]      mul_a_s, mul_b_s;
  logic [2*DW-1:0]    prod_q;

  // window ram
  logic               ram_we_s;
  logic [PTW-1:0]     ram_raddr_s;
  logic [PRICE_W-1:0] ram_rdata_s;

  // output register
  logic               out_valid_q;
  logic [SIG_W-1:0]   out_sig_q;
  logic               out_ready_q, out_blk_q;

  // combinational values
  logic               full_s;
  logic [DW-1:0]      wc_s;
  logic [DW-1:0]      d_d;
  logic               d_neg_d;
  logic [PLW:0]       path_ext_s;
  logic [PLW-1:0]     path_d;
  logic [VW-1:0]      wq_s;
  logic [PRICE_W-1:0] net_s;
  logic               blocked_d;
  logic               fire_s;
  logic [SIG_W-1:0]   sig_d;
  logic [SW-1:0]      sum_d;
  logic [QW-1:0]      sq_d;
  logic [PTW-1:0]     wp_d;
  logic [HCW-1:0]     count_d;

  // ring slot of the close held age bars back
  function automatic logic [PTW-1:0] slot_of(input logic [PTW-1:0] wp,
                                             input logic [PTW:0]   age);
    logic [PTW:0] t;
    t = {1'b0, wp} + (PTW+1)'(BAND_WINDOW) - age;
    if (t >= (PTW+1)'(BAND_WINDOW)) begin
      t = t - (PTW+1)'(BAND_WINDOW);
    end
    return t[PTW-1:0];
  endfunction

  function automatic logic [PRICE_W-1:0] absdiff(input logic [PRICE_W-1:0] a,
                                                 input logic [PRICE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept_s      = s_axis_tvalid && s_axis_tready;
  assign commit_s      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign full_s        = (count_q >= HCW'(BAND_WINDOW));

  // settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regime_en_q <= RST_REGIME_ENABLE;
      thr_q       <= RST_EFF_THRESHOLD;
      kmul_q      <= RST_BAND_MULT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_REGIME_ENABLE: regime_en_q <= cfg_data_i[0];
        REG_EFF_THRESHOLD: thr_q       <= cfg_data_i[THR_W-1:0];
        REG_BAND_MULT:     kmul_q      <= cfg_data_i[MULT_W-1:0];
        default:           ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, ram read address and multiplier operands
  always_comb begin
    state_d     = state_q;
    ram_raddr_s = wp_q;
    mul_a_s     = '0;
    mul_b_s     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept_s) state_d = ST_RD_PREV;
      end
      ST_RD_PREV: begin
        ram_raddr_s = slot_of(wp_q, (PTW+1)'(1));
        mul_a_s     = DW'(c_q);
        mul_b_s     = DW'(c_q);
        state_d     = ST_RD_EFF;
      end
      ST_RD_EFF: begin
        ram_raddr_s = slot_of(wp_q, (PTW+1)'(EFFICIENCY_LENGTH));
        mul_a_s     = DW'(sum_q);
        mul_b_s     = DW'(sum_q);
        state_d     = ST_RD_EFF1;
      end
      ST_RD_EFF1: begin
        ram_raddr_s = slot_of(wp_q, (PTW+1)'(EFFICIENCY_LENGTH + 1));
        mul_a_s     = d_q;
        mul_b_s     = d_q;
        state_d     = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        ram_raddr_s = wp_q;
        mul_a_s     = DW'(kmul_q);
        mul_b_s     = DW'(kmul_q);
        state_d     = ST_TAKE_OLD;
      end
      ST_TAKE_OLD: begin
        mul_a_s = DW'(thr_q);
        mul_b_s = DW'(npath_q);
        state_d = ST_GATE;
      end
      ST_GATE: begin
        mul_a_s = DW'(old_q);
        mul_b_s = DW'(old_q);
        state_d = ST_RHS_LO;
      end
      ST_RHS_LO: begin
        mul_a_s = DW'(k2w_q);
        mul_b_s = v_q[DW-1:0];
        state_d = ST_RHS_HI;
      end
      ST_RHS_HI: begin
        mul_a_s = DW'(k2w_q);
        mul_b_s = v_q[VW-1:DW];
        state_d = ST_RHS_SUM;
      end
      ST_RHS_SUM: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (commit_s) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk_i) begin
    prod_q <= (2*DW)'(mul_a_s) * (2*DW)'(mul_b_s);
  end

  // band distance, path update, variance and gate
  always_comb begin
    wc_s    = DW'(c_q) * DW'(BAND_WINDOW);
    d_neg_d = (wc_s < sum_q);
    d_d     = d_neg_d ? (sum_q - wc_s) : (wc_s - sum_q);

    path_ext_s = {1'b0, path_q};
    if (count_q >= HCW'(1)) begin
      path_ext_s = path_ext_s + (PLW+1)'(absdiff(c_q, a1_q));
    end
    if (count_q >= HCW'(EFFICIENCY_LENGTH + 1)) begin
      path_ext_s = path_ext_s - (PLW+1)'(absdiff(ae_q, ram_rdata_s));
    end
    path_d = path_ext_s[PLW-1:0];

    wq_s  = VW'(sq_q) * VW'(BAND_WINDOW);
    net_s = absdiff(c_q, ae_q);

    // ratio at or above threshold, a zero path counting as ratio zero
    blocked_d = 1'b0;
    if (full_s && regime_en_q) begin
      if (npath_q == '0) begin
        blocked_d = (thr_q == '0);
      end else begin
        blocked_d = ((THPW'(net_s) << THR_W) >= thp_q);
      end
    end

    fire_s = full_s && !blocked_q && var_pos_q && (d_q != '0) && (lhs_q > rhs_q);
    sig_d  = fire_s ? (d_neg_q ? SIG_LONG : SIG_SHORT) : SIG_NONE;
  end

  // bar working registers
  always_ff @(posedge clk_i) begin
    if (accept_s) begin
      c_q <= s_axis_tdata[PRICE_W-1:0];
    end
    case (state_q)
      ST_RD_PREV: begin
        d_q     <= d_d;
        d_neg_q <= d_neg_d;
      end
      ST_RD_EFF: begin
        a1_q  <= ram_rdata_s;
        csq_q <= prod_q[CSQW-1:0];
      end
      ST_RD_EFF1: begin
        ae_q <= ram_rdata_s;
        ss_q <= prod_q;
      end
      ST_RD_OLD: begin
        npath_q   <= path_d;
        dsq_q     <= prod_q;
        v_q       <= wq_s - ss_q;
        var_pos_q <= (wq_s > ss_q);
      end
      ST_TAKE_OLD: begin
        old_q <= ram_rdata_s;
        k2_q  <= prod_q[2*MULT_W-1:0];
        lhs_q <= (CW'(dsq_q) * CW'(BAND_WINDOW - 1)) << THR_W;
      end
      ST_GATE: begin
        thp_q <= prod_q[THPW-1:0];
        k2w_q <= K2W'(k2_q) * K2W'(BAND_WINDOW);
      end
      ST_RHS_LO: begin
        osq_q     <= prod_q[CSQW-1:0];
        blocked_q <= blocked_d;
      end
      ST_RHS_HI: begin
        rlo_q <= prod_q;
      end
      ST_RHS_SUM: begin
        rhs_q <= (CW'(prod_q) << DW) + CW'(rlo_q);
      end
      default: ;
    endcase
  end

  // history update at commit
  always_comb begin
    sum_d   = sum_q + SW'(c_q);
    sq_d    = sq_q + QW'(csq_q);
    count_d = count_q + HCW'(1);
    if (full_s) begin
      sum_d   = sum_d - SW'(old_q);
      sq_d    = sq_d - QW'(osq_q);
      count_d = count_q;
    end
    wp_d = (wp_q == PTW'(BAND_WINDOW - 1)) ? '0 : (wp_q + PTW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      path_q  <= '0;
    end else if (accept_s && s_axis_tuser[0]) begin
      wp_q    <= '0;
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      path_q  <= '0;
    end else if (commit_s) begin
      wp_q    <= wp_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      path_q  <= npath_q;
    end
  end

  // close window
  assign ram_we_s = commit_s;

  rgbr_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (BAND_WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we_s),
    .waddr_i (wp_q),
    .wdata_i (c_q),
    .raddr_i (ram_raddr_s),
    .rdata_o (ram_rdata_s)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_s) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_s) begin
      out_sig_q   <= sig_d;
      out_ready_q <= full_s;
      out_blk_q   <= blocked_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - SIG_W)'(0), out_sig_q};
  assign m_axis_tuser  = {out_blk_q, out_ready_q};

endmodule

`default_nettype wire
